[hdl/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
// Depends on nothing; pulled in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ple_pkg.sv]
// Package for the positional list engine: field widths, defaults, op codes.
// No dependencies.
package ple_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_WORD_WIDTH = 32;

	localparam int OP_W    = 4;
	localparam int IDX_W   = 6;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_GET      = 4'd0,
		OP_SET      = 4'd1,
		OP_INSERT   = 4'd2,
		OP_DELETE   = 4'd3,
		OP_SWAP     = 4'd4,
		OP_CONTAINS = 4'd5,
		OP_CLEAR    = 4'd6,
		OP_PUSH     = 4'd7,
		OP_POP      = 4'd8
	} op_t;

endpackage

[hdl/ple_req_if.sv]
// Request channel of the list engine: valid/ready plus request payload.
// Depends on ple_pkg.
interface ple_req_if import ple_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [IDX_W-1:0]   index;
	logic [IDX_W-1:0]   second_index;
	logic [VALUE_W-1:0] value;

	modport source (output valid, operation, index, second_index, value, input ready);
	modport sink   (input valid, operation, index, second_index, value, output ready);
endinterface

[hdl/ple_rsp_if.sv]
// Response channel of the list engine: valid/ready plus result payload.
// Depends on ple_pkg.
interface ple_rsp_if import ple_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               status;
	logic [VALUE_W-1:0] read_value;
	logic               found;
	logic [COUNT_W-1:0] count;

	modport source (output valid, status, read_value, found, count, input ready);
	modport sink   (input valid, status, read_value, found, count, output ready);
endinterface

[hdl/ple_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/positional_list_engine.sv]
// Top level of the positional list engine: sequencer around one list RAM.
// Depends on ple_pkg, ple_req_if, ple_rsp_if, ple_ram and assert_macros.svh.
//
//   req (sink): one transfer carries operation, index, second_index, value.
//   rsp (source): exactly one transfer per request with status, read_value,
//   found and count (entries in use after the request).
//   One request is in flight at a time; req.ready is high only while the
//   sequencer is idle. All list work goes through a single RAM port pair
//   (one write, one registered read per cycle), so cost scales with the
//   number of entries touched: insert/push/delete/pop with the entries moved,
//   contains and clear with the count; get, set, swap and a refused request
//   do not depend on it. req.ready returns high in the same cycle as the output
//   register loads the result. Reset: after arst_n releases, a pass writes
//   zero into every slot, with req.ready low.
//   Stall: the result sits in an output register; a new request is taken
//   while it waits, and the next result holds in the final step until the
//   output register has been taken.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);
	`include "assert_macros.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	// width wide enough for index and count compares
	localparam int EW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [8:0] {
		S_ZERO = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_GETR = 9'b000000100,
		S_GETW = 9'b000001000,
		S_SET  = 9'b000010000,
		S_SWAP = 9'b000100000,
		S_MOVE = 9'b001000000,
		S_TAIL = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t                state_q;
	logic                  boot_q;
	op_t                   op_q;
	logic [AW-1:0]         pos_q, pos2_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         rp_q, wp_q;
	logic [CW-1:0]         rem_q;
	logic                  pv_q;
	logic [1:0]            step_q;
	logic [WORD_WIDTH-1:0] tmp_q;
	logic                  fail_q;
	logic [WORD_WIDTH-1:0] rd_q;
	logic                  hit_q;

	logic                  rsp_valid_q;
	logic                  rsp_status_q;
	logic [VALUE_W-1:0]    rsp_read_q;
	logic                  rsp_found_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	// RAM port
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

	// request decode
	logic [WORD_WIDTH-1:0] in_word;
	logic [EW-1:0]         idx_e, idx2_e, cnt_e, cap_e, ins_pos_e, del_pos_e;
	state_t                dec_state;
	logic                  dec_fail;
	logic [AW-1:0]         dec_pos, dec_rp, dec_wp;
	logic [CW-1:0]         dec_rem;

	logic move_up;      // shift toward higher addresses' source (delete, scan)
	logic move_scan;    // contains: compare instead of write
	logic shift_ins;    // insert or push

	assign req.ready = (state_q == S_IDLE);
	assign in_word   = WORD_WIDTH'(req.value);
	assign idx_e     = EW'(req.index);
	assign idx2_e    = EW'(req.second_index);
	assign cnt_e     = EW'(cnt_q);
	assign cap_e     = EW'(CAPACITY);
	assign ins_pos_e = (op_t'(req.operation) == OP_PUSH) ? cnt_e : idx_e;
	assign del_pos_e = (op_t'(req.operation) == OP_POP) ? cnt_e - 1'b1 : idx_e;

	assign shift_ins = (op_q == OP_INSERT) || (op_q == OP_PUSH);
	assign move_scan = (op_q == OP_CONTAINS);
	assign move_up   = !shift_ins;

	always_comb begin
		dec_state = S_FIN;
		dec_fail  = 1'b1;
		dec_pos   = AW'(req.index);
		dec_rp    = '0;
		dec_wp    = '0;
		dec_rem   = '0;
		unique case (op_t'(req.operation)) inside
			OP_GET: begin
				if (idx_e < cap_e) begin
					dec_state = S_GETR;
					dec_fail  = 1'b0;
				end
			end
			OP_SET: begin
				if (idx_e < cap_e) begin
					dec_state = S_SET;
					dec_fail  = 1'b0;
				end
			end
			OP_INSERT, OP_PUSH: begin
				if (in_word != '0 && cnt_e < cap_e && ins_pos_e <= cnt_e) begin
					dec_state = S_MOVE;
					dec_fail  = 1'b0;
					dec_pos   = AW'(ins_pos_e);
					dec_rp    = AW'(cnt_e - 1'b1);
					dec_wp    = AW'(cnt_e);
					dec_rem   = CW'(cnt_e - ins_pos_e);
				end
			end
			OP_DELETE, OP_POP: begin
				if (cnt_e != '0 && del_pos_e < cnt_e) begin
					dec_state = S_MOVE;
					dec_fail  = 1'b0;
					dec_pos   = AW'(del_pos_e);
					dec_rp    = AW'(del_pos_e + 1'b1);
					dec_wp    = AW'(del_pos_e);
					dec_rem   = CW'(cnt_e - del_pos_e - 1'b1);
				end
			end
			OP_SWAP: begin
				if (idx_e < cnt_e && idx2_e < cnt_e) begin
					dec_state = S_SWAP;
					dec_fail  = 1'b0;
				end
			end
			OP_CONTAINS: begin
				dec_state = S_MOVE;
				dec_fail  = 1'b0;
				dec_rem   = cnt_q;
			end
			OP_CLEAR: begin
				dec_state = S_ZERO;
				dec_fail  = 1'b0;
				dec_rem   = cnt_q;
			end
			default: begin
				dec_state = S_FIN;
			end
		endcase
	end

	// RAM port steering per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = ram_rdata;
		ram_raddr = rp_q;
		unique case (state_q)
			S_ZERO: begin
				ram_we    = (rem_q != '0);
				ram_wdata = '0;
			end
			S_GETR: ram_raddr = pos_q;
			S_SET: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = word_q;
			end
			S_SWAP: begin
				case (step_q)
					2'd0: ram_raddr = pos_q;
					2'd1: ram_raddr = pos2_q;
					2'd2: begin
						ram_we    = 1'b1;
						ram_waddr = pos_q;
					end
					default: begin
						ram_we    = 1'b1;
						ram_waddr = pos2_q;
						ram_wdata = tmp_q;
					end
				endcase
			end
			S_MOVE: ram_we = pv_q && !move_scan;
			S_TAIL: begin
				ram_we = 1'b1;
				if (shift_ins) begin
					ram_waddr = pos_q;
					ram_wdata = word_q;
				end else begin
					ram_waddr = AW'(cnt_q - 1'b1);
					ram_wdata = '0;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	ple_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ZERO;
			boot_q      <= 1'b1;
			cnt_q       <= '0;
			wp_q        <= '0;
			rem_q       <= CW'(CAPACITY);
			rp_q        <= '0;
			pv_q        <= 1'b0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register: load from the final step, else empty on transfer
			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ZERO: begin
					if (rem_q == '0) begin
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= '0;
							state_q <= S_FIN;
						end
					end else begin
						wp_q  <= wp_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= dec_state;
						rp_q    <= dec_rp;
						wp_q    <= dec_wp;
						rem_q   <= dec_rem;
						pv_q    <= 1'b0;
						step_q  <= '0;
					end
				end
				S_GETR: state_q <= S_GETW;
				S_GETW: state_q <= S_FIN;
				S_SET:  state_q <= S_FIN;
				S_SWAP: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						state_q <= S_FIN;
					end
				end
				S_MOVE: begin
					// one read issued and one prior read retired per cycle
					if (rem_q != '0) begin
						rp_q  <= move_up ? rp_q + 1'b1 : rp_q - 1'b1;
						rem_q <= rem_q - 1'b1;
					end
					pv_q <= (rem_q != '0);
					if (pv_q) begin
						wp_q <= move_up ? wp_q + 1'b1 : wp_q - 1'b1;
					end
					if (rem_q == '0 && !pv_q) begin
						state_q <= move_scan ? S_FIN : S_TAIL;
					end
				end
				S_TAIL: begin
					cnt_q   <= shift_ins ? cnt_q + 1'b1 : cnt_q - 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request fields and per-request results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q   <= op_t'(req.operation);
			pos_q  <= dec_pos;
			pos2_q <= AW'(req.second_index);
			word_q <= in_word;
			fail_q <= dec_fail;
			rd_q   <= '0;
			hit_q  <= 1'b0;
		end
		if (state_q == S_GETW) begin
			rd_q <= ram_rdata;
		end
		if (state_q == S_SWAP && step_q == 2'd1) begin
			tmp_q <= ram_rdata;
		end
		if (state_q == S_MOVE && move_scan && pv_q && ram_rdata == word_q) begin
			hit_q <= 1'b1;
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_status_q <= fail_q;
			rsp_read_q   <= VALUE_W'(rd_q);
			rsp_found_q  <= hit_q;
			rsp_count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_value = rsp_read_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.count      = rsp_count_q;

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CW'(CAPACITY), "count above capacity")
	`ASSERT_IMPLIES(a_cnt_step, clk, arst_n, cnt_q != $past(cnt_q), cnt_q == CW'($past(cnt_q) + 1'b1) || cnt_q == CW'($past(cnt_q) - 1'b1) || cnt_q == '0, "count jumped")
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, state_q != S_IDLE, "request left sequencer idle")
	`ASSERT_IMPLIES(a_no_rsp_boot, clk, arst_n, boot_q, !rsp_valid_q && !ram_we || state_q == S_ZERO, "activity during reset wipe")
endmodule
